// ===== rtl/pid_axis_controller_top_assert.svh =====
// Assertion macros shared by the PID axis controller RTL.
`ifndef PID_AXIS_CONTROLLER_TOP_ASSERT_SVH
`define PID_AXIS_CONTROLLER_TOP_ASSERT_SVH

// cond must hold at every edge outside reset
`define PAC_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pac assertion failed");

// ante at one edge implies cons at the next
`define PAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pac assertion failed");

`endif

// ===== rtl/pac_pkg.sv =====
// Package: widths, register codes, reset values and types of the PID axis controller.
package pac_pkg;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int DT_W   = 20;
  localparam int IDX_W  = 3;
  localparam int NUM_W  = DATA_W + 1 + DT_W;
  localparam int DEN_W  = DT_W + 1;
  localparam int LIM_W  = DATA_W - 1;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_LIM    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FILT_TAU   = 3'd5;

  localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 32'd9830400;
  localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 32'd655360;
  localparam logic [DATA_W-1:0] DERIV_GAIN_RST = 32'd327680;
  localparam logic [LIM_W-1:0]  INTEG_LIM_RST  = 31'd294912000;
  localparam logic [LIM_W-1:0]  OUT_LIM_RST    = 31'd901120000;
  localparam logic [DT_W-1:0]   FILT_TAU_RST   = 20'd5563;

  // 0.0001 s in Q0.20, rounded
  localparam logic [DT_W-1:0] DT_MIN = 20'd105;

  typedef struct packed {
    logic start;
    logic dt_shift;
  } mul_ctl_t;
endpackage

// ===== rtl/pac_item_if.sv =====
// Input channel interface: compute and prime transactions.
interface pac_item_if import pac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic [DT_W-1:0]          step_time;

  modport source (output valid, op, setpoint, measured, step_time, input ready);
  modport sink (input valid, op, setpoint, measured, step_time, output ready);
endinterface

// ===== rtl/pac_result_if.sv =====
// Result channel interface: controller output transactions.
interface pac_result_if import pac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     clamped;

  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

// ===== rtl/pac_cfg_if.sv =====
// Configuration write channel interface.
interface pac_cfg_if import pac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pac_mul.sv =====
// Shared multiply unit: signed value times unsigned gain, rounded shift, saturate.
module pac_mul import pac_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mul_ctl_t                 ctl,
  input  logic signed [DATA_W:0]   a,
  input  logic [DATA_W-1:0]        g,
  output logic                     done,
  output logic signed [DATA_W-1:0] res
);
  logic [DATA_W:0]     amag;
  logic [2*DATA_W-1:0] pp;
  logic [2*DATA_W:0]   prod_next;
  logic [2*DATA_W:0]   prod;
  logic                neg;
  logic                shsel;
  logic                busy;
  logic [2*DATA_W+1:0] rnd;
  logic [2*DATA_W+1:0] shifted;
  logic [DATA_W:0]     lim;
  logic [DATA_W:0]     mres;
  logic [DATA_W:0]     sres;

  always_comb begin
    amag = a[DATA_W] ? (~a + 1'b1) : a;
    pp = amag[DATA_W-1:0] * g;
    prod_next = {1'b0, pp} +
                (amag[DATA_W] ? {1'b0, g, {DATA_W{1'b0}}} : {(2*DATA_W+1){1'b0}});
    rnd = {1'b0, prod} + (shsel ? ((2*DATA_W+2)'(1) << (DT_W - 1))
                                : ((2*DATA_W+2)'(1) << (FRAC_W - 1)));
    shifted = shsel ? (rnd >> DT_W) : (rnd >> FRAC_W);
    lim = neg ? ((DATA_W+1)'(1) << (DATA_W - 1)) : (((DATA_W+1)'(1) << (DATA_W - 1)) - 1'b1);
    mres = (shifted > {{(DATA_W+1){1'b0}}, lim}) ? lim : shifted[DATA_W:0];
    sres = neg ? (~mres + 1'b1) : mres;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod  <= prod_next;
      neg   <= a[DATA_W];
      shsel <= ctl.dt_shift;
    end
    if (busy) begin
      res <= sres[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= ctl.start;
      done <= busy;
    end
  end
endmodule

// ===== rtl/pac_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module pac_div import pac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, dreg};
    qbit  = (trial >= {1'b0, dreg});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/pid_axis_controller_top.sv =====
// PID axis controller top level: register file, step sequencer and controller state.
// A compute transaction runs five passes through the shared multiply unit and two passes
// through the shared radix-2 divider (derivative rate and filter coefficient), then waits
// in the sum state until the output register is free. A prime transaction gives no result.
// The input is ready only while the sequencer is idle; a finished result waits in the
// output register and does not hold off the next transaction.
`include "pid_axis_controller_top_assert.svh"

module pid_axis_controller_top import pac_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pac_item_if.sink     in_ch,
  pac_result_if.source out_ch,
  pac_cfg_if.sink      cfg
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PMUL  = 4'd1;
  localparam logic [3:0] ST_IMUL  = 4'd2;
  localparam logic [3:0] ST_ITERM = 4'd3;
  localparam logic [3:0] ST_RDIV  = 4'd4;
  localparam logic [3:0] ST_DMUL  = 4'd5;
  localparam logic [3:0] ST_ADIV  = 4'd6;
  localparam logic [3:0] ST_FMUL  = 4'd7;
  localparam logic [3:0] ST_SUM   = 4'd8;

  localparam logic signed [DATA_W+1:0] FD_MAX = {3'b000, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W+1:0] FD_MIN = {3'b111, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] prop_gain, integ_gain, deriv_gain;
  logic [LIM_W-1:0]  integral_limit, output_limit;
  logic [DT_W-1:0]   filter_tau;

  logic signed [DATA_W-1:0] integral_acc, prev_measured, filtered_deriv;
  logic signed [DATA_W-1:0] ms, pterm, iterm, rate, raw;
  logic signed [DATA_W:0]   err;
  logic [DT_W-1:0]          dt;
  logic [DT_W:0]            alpha;
  logic [3:0]               state;
  logic                     issued;

  mul_ctl_t                 mctl;
  logic signed [DATA_W:0]   ma;
  logic [DATA_W-1:0]        mg;
  logic                     mdone;
  logic signed [DATA_W-1:0] mres;
  logic                     dstart;
  logic [NUM_W-1:0]         dnum;
  logic [DEN_W-1:0]         dden;
  logic                     ddone;
  logic [NUM_W-1:0]         dquo;

  logic                     in_acc;
  logic signed [DATA_W:0]   delta;
  logic [DATA_W:0]          dmag;
  logic signed [DATA_W+1:0] isum, fsum, osum, ilim_x, olim_x, drv_x;
  logic signed [DATA_W-1:0] acc_next, fd_next, sum_next;
  logic [NUM_W-1:0]         rlim;
  logic [NUM_W-1:0]         rsat;
  logic [DATA_W-1:0]        rate_next;
  logic                     clamp_next;
  logic                     out_free;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    mctl.start    = 1'b0;
    mctl.dt_shift = 1'b0;
    ma            = err;
    mg            = prop_gain;
    case (state)
      ST_PMUL: begin
        mctl.start = !issued;
      end
      ST_IMUL: begin
        mctl.start    = !issued;
        mctl.dt_shift = 1'b1;
        mg            = {{(DATA_W-DT_W){1'b0}}, dt};
      end
      ST_ITERM: begin
        mctl.start = !issued;
        ma         = {integral_acc[DATA_W-1], integral_acc};
        mg         = integ_gain;
      end
      ST_DMUL: begin
        mctl.start = !issued;
        ma         = {rate[DATA_W-1], rate};
        mg         = deriv_gain;
      end
      ST_FMUL: begin
        mctl.start    = !issued;
        mctl.dt_shift = 1'b1;
        ma            = {raw[DATA_W-1], raw} - {filtered_deriv[DATA_W-1], filtered_deriv};
        mg            = {{(DATA_W-DT_W-1){1'b0}}, alpha};
      end
      default: begin
        mctl.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    delta = {ms[DATA_W-1], ms} - {prev_measured[DATA_W-1], prev_measured};
    dmag  = delta[DATA_W] ? (~delta + 1'b1) : delta;
    dstart = ((state == ST_RDIV) || (state == ST_ADIV)) && !issued;
    if (state == ST_RDIV) begin
      dnum = {dmag, {DT_W{1'b0}}};
      dden = {1'b0, dt};
    end else begin
      dnum = {{(NUM_W-2*DT_W){1'b0}}, dt, {DT_W{1'b0}}};
      dden = {1'b0, filter_tau} + {1'b0, dt};
    end
    rlim = delta[DATA_W] ? (NUM_W'(1) << (DATA_W - 1)) : ((NUM_W'(1) << (DATA_W - 1)) - 1'b1);
    rsat = (dquo > rlim) ? rlim : dquo;
    rate_next = delta[DATA_W] ? (~rsat[DATA_W-1:0] + 1'b1) : rsat[DATA_W-1:0];

    ilim_x = {3'b000, integral_limit};
    olim_x = {3'b000, output_limit};
    isum = {{2{integral_acc[DATA_W-1]}}, integral_acc} + {{2{mres[DATA_W-1]}}, mres};
    if (isum > ilim_x) begin
      acc_next = ilim_x[DATA_W-1:0];
    end else if (isum < -ilim_x) begin
      acc_next = DATA_W'(-ilim_x);
    end else begin
      acc_next = isum[DATA_W-1:0];
    end

    fsum = {{2{filtered_deriv[DATA_W-1]}}, filtered_deriv} + {{2{mres[DATA_W-1]}}, mres};
    if (fsum > FD_MAX) begin
      fd_next = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (fsum < FD_MIN) begin
      fd_next = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      fd_next = fsum[DATA_W-1:0];
    end

    osum = {{2{pterm[DATA_W-1]}}, pterm} + {{2{iterm[DATA_W-1]}}, iterm}
         - {{2{filtered_deriv[DATA_W-1]}}, filtered_deriv};
    clamp_next = 1'b1;
    if (osum > olim_x) begin
      sum_next = olim_x[DATA_W-1:0];
    end else if (osum < -olim_x) begin
      sum_next = DATA_W'(-olim_x);
    end else begin
      sum_next   = osum[DATA_W-1:0];
      clamp_next = 1'b0;
    end
    drv_x = {{2{out_ch.drive[DATA_W-1]}}, out_ch.drive};
  end

  pac_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .a    (ma),
    .g    (mg),
    .done (mdone),
    .res  (mres)
  );

  pac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      integ_gain     <= INTEG_GAIN_RST;
      deriv_gain     <= DERIV_GAIN_RST;
      integral_limit <= INTEG_LIM_RST;
      output_limit   <= OUT_LIM_RST;
      filter_tau     <= FILT_TAU_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PROP_GAIN:  prop_gain <= cfg.data;
        REG_INTEG_GAIN: integ_gain <= cfg.data;
        REG_DERIV_GAIN: deriv_gain <= cfg.data;
        REG_INTEG_LIM:  integral_limit <= cfg.data[LIM_W-1:0];
        REG_OUT_LIM:    output_limit <= cfg.data[LIM_W-1:0];
        REG_FILT_TAU:   filter_tau <= cfg.data[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      err <= {in_ch.setpoint[DATA_W-1], in_ch.setpoint}
           - {in_ch.measured[DATA_W-1], in_ch.measured};
      ms  <= in_ch.measured;
      dt  <= (in_ch.step_time < DT_MIN) ? DT_MIN : in_ch.step_time;
    end
    if (mdone && (state == ST_PMUL)) begin
      pterm <= mres;
    end
    if (mdone && (state == ST_ITERM)) begin
      iterm <= mres;
    end
    if (ddone && (state == ST_RDIV)) begin
      rate <= rate_next;
    end
    if (mdone && (state == ST_DMUL)) begin
      raw <= mres;
    end
    if (ddone && (state == ST_ADIV)) begin
      alpha <= dquo[DT_W:0];
    end
    if ((state == ST_SUM) && out_free) begin
      out_ch.drive   <= sum_next;
      out_ch.clamped <= clamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      issued         <= 1'b0;
      integral_acc   <= '0;
      prev_measured  <= '0;
      filtered_deriv <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (mctl.start || dstart) begin
        issued <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready && !((state == ST_SUM) && out_free)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.op) begin
              integral_acc  <= '0;
              prev_measured <= in_ch.measured;
            end else begin
              state <= ST_PMUL;
            end
          end
        end
        ST_PMUL: begin
          if (mdone) begin
            issued <= 1'b0;
            state  <= ST_IMUL;
          end
        end
        ST_IMUL: begin
          if (mdone) begin
            issued       <= 1'b0;
            integral_acc <= acc_next;
            state        <= ST_ITERM;
          end
        end
        ST_ITERM: begin
          if (mdone) begin
            issued <= 1'b0;
            state  <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (ddone) begin
            issued        <= 1'b0;
            prev_measured <= ms;
            state         <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          if (mdone) begin
            issued <= 1'b0;
            state  <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (ddone) begin
            issued <= 1'b0;
            state  <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          if (mdone) begin
            issued         <= 1'b0;
            filtered_deriv <= fd_next;
            state          <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PAC_ASSERT_NEXT(a_busy_after_compute, in_acc && !in_ch.op, state != ST_IDLE)
  `PAC_ASSERT_HOLDS(a_drive_in_limit, !out_ch.valid || (drv_x <= olim_x && drv_x >= -olim_x))
  `PAC_ASSERT_HOLDS(a_clamp_at_limit, !out_ch.valid || !out_ch.clamped || drv_x == olim_x || drv_x == -olim_x)
  `PAC_ASSERT_HOLDS(a_one_unit_at_once, !(mctl.start && dstart))
endmodule
